/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the keypad calculator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HKC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hkc assertion failed");
`define HKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hkc assertion failed");
`else
`define HKC_ASSERT(label, clk, rst, prop)
`define HKC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/hkc_pkg.sv */
// ----------------------------------------------------------------------------
// hkc_pkg
// Types, codes and constants of the hex keypad calculator.
// ----------------------------------------------------------------------------
package hkc_pkg;

   localparam int DATA_W          = 32;
   localparam int KIND_W          = 2;
   localparam int KEY_W           = 8;
   localparam int UNIT_W          = 4;
   localparam int STEP_W          = $clog2(DATA_W);
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [DATA_W-1:0] DIGIT_LIMIT = 32'h0FFF_FFFF;
   localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

   localparam logic [KEY_W-1:0] CHR_PLUS  = 8'h2B;
   localparam logic [KEY_W-1:0] CHR_MINUS = 8'h2D;
   localparam logic [KEY_W-1:0] CHR_STAR  = 8'h2A;
   localparam logic [KEY_W-1:0] CHR_SLASH = 8'h2F;
   localparam logic [KEY_W-1:0] CHR_PCT   = 8'h25;
   localparam logic [KEY_W-1:0] CHR_EQU   = 8'h3D;
   localparam logic [KEY_W-1:0] CHR_AMP   = 8'h26;
   localparam logic [KEY_W-1:0] CHR_BAR   = 8'h7C;
   localparam logic [KEY_W-1:0] CHR_CARET = 8'h5E;
   localparam logic [KEY_W-1:0] CHR_GT    = 8'h3E;
   localparam logic [KEY_W-1:0] CHR_LT    = 8'h3C;

   typedef enum logic [KIND_W-1:0] {
      KIND_DIGIT = 2'd0,
      KIND_BACK  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_OPER  = 2'd3
   } key_kind_type;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_AND = 4'd5,
      OP_OR  = 4'd6,
      OP_XOR = 4'd7,
      OP_SHR = 4'd8,
      OP_SHL = 4'd9,
      OP_EQU = 4'd10
   } op_type;

   typedef struct packed {
      key_kind_type        kind;
      logic [UNIT_W-1:0]   unit;
      op_type              op;
   } cmd_type;

   typedef struct packed {
      logic                start;
      logic                is_mod;
      logic [DATA_W-1:0]   dividend;
      logic [DATA_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DATA_W-1:0]   result;
   } div_rsp_type;

   typedef struct packed {
      logic                full;
      logic                empty;
   } q_stat_type;

endpackage

/* hw/rtl/hkc_req_if.sv */
// ----------------------------------------------------------------------------
// hkc_req_if
// Key request channel: valid/ready handshake with the classified key.
// ----------------------------------------------------------------------------
interface hkc_req_if;
   import hkc_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [KEY_W-1:0]   key_value;

   modport source (output valid, output kind, output key_value, input ready);
   modport sink   (input valid, input kind, input key_value, output ready);
endinterface

/* hw/rtl/hkc_rsp_if.sv */
// ----------------------------------------------------------------------------
// hkc_rsp_if
// Display response channel: valid/ready handshake with the display result.
// ----------------------------------------------------------------------------
interface hkc_rsp_if;
   import hkc_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  display_value;
   logic               display_update;
   logic               entry_warning;

   modport source (output valid, output display_value, output display_update,
                   output entry_warning, input ready);
   modport sink   (input valid, input display_value, input display_update,
                   input entry_warning, output ready);
endinterface

/* hw/rtl/hex_keypad_calculator.sv */
// ----------------------------------------------------------------------------
// hex_keypad_calculator
// Hexadecimal calculator driven by classified key presses.
// ----------------------------------------------------------------------------
// Each accepted key request yields exactly one display response. Requests are
// classified and queued, so the request side keeps accepting until the queue
// is full while a response waits on the display side. Digit, backspace, clear
// and every operator that needs no division are executed from the queue head
// into the registered response once the previous response has been taken. An
// operator key whose pending operation is / or % with a nonzero divisor runs
// the shared radix-2 divider, one quotient bit per cycle, and no further key
// leaves the queue until the divider is done.
module hex_keypad_calculator #(
   parameter int QUEUE_DEPTH = hkc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hkc_req_if.sink   req_chan,
   hkc_rsp_if.source rsp_chan
);
   import hkc_pkg::*;

   q_stat_type q_stat;
   cmd_type    q_cmd;
   cmd_type    q_head;
   logic       q_push;
   logic       q_pop;

   hkc_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   hkc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_cmd  (q_cmd),
      .q_pop  (q_pop),
      .q_stat (q_stat),
      .q_head (q_head)
   );

   hkc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* hw/rtl/hkc_front.sv */
// ----------------------------------------------------------------------------
// hkc_front
// Accept key requests and classify them into execute commands.
// ----------------------------------------------------------------------------
module hkc_front (
   hkc_req_if.sink             req_chan,
   input  hkc_pkg::q_stat_type q_stat,
   output logic                q_push,
   output hkc_pkg::cmd_type    q_cmd
);
   import hkc_pkg::*;

   op_type op;

   always_comb begin
      case (req_chan.key_value)
         CHR_PLUS:  op = OP_ADD;
         CHR_MINUS: op = OP_SUB;
         CHR_STAR:  op = OP_MUL;
         CHR_SLASH: op = OP_DIV;
         CHR_PCT:   op = OP_MOD;
         CHR_AMP:   op = OP_AND;
         CHR_BAR:   op = OP_OR;
         CHR_CARET: op = OP_XOR;
         CHR_GT:    op = OP_SHR;
         CHR_LT:    op = OP_SHL;
         default:   op = OP_EQU;
      endcase
   end

   assign req_chan.ready = !q_stat.full;
   assign q_push         = req_chan.valid && !q_stat.full;
   assign q_cmd.kind     = key_kind_type'(req_chan.kind);
   assign q_cmd.unit     = req_chan.key_value[UNIT_W-1:0];
   assign q_cmd.op       = op;

endmodule

/* hw/rtl/hkc_queue.sv */
// ----------------------------------------------------------------------------
// hkc_queue
// Short command queue between the classify front and the execute back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkc_queue #(
   parameter int DEPTH = hkc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  hkc_pkg::cmd_type    q_cmd,
   input  logic                q_pop,
   output hkc_pkg::q_stat_type q_stat,
   output hkc_pkg::cmd_type    q_head
);
   import hkc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = q_push && !q_stat.full;
   assign do_pop       = q_pop && !q_stat.empty;
   assign q_head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_cmd;
      end
   end

   `HKC_ASSERT(a_q_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))

endmodule

/* hw/rtl/hkc_div.sv */
// ----------------------------------------------------------------------------
// hkc_div
// Signed 32-bit divide and modulo, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  hkc_pkg::div_req_type div_req,
   output hkc_pkg::div_rsp_type div_rsp
);
   import hkc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [DATA_W-1:0]   dsr_ff, dsr_in;
   logic                is_mod_ff, is_mod_in;
   logic                neg_q_ff, neg_q_in;
   logic                neg_r_ff, neg_r_in;
   logic [DATA_W:0]     trial;
   logic [DATA_W-1:0]   mag_a, mag_b;

   assign mag_a = div_req.dividend[DATA_W-1] ? (~div_req.dividend + 1'b1)
                                             : div_req.dividend;
   assign mag_b = div_req.divisor[DATA_W-1]  ? (~div_req.divisor + 1'b1)
                                             : div_req.divisor;
   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dsr_ff};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      is_mod_in = is_mod_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      if (div_req.start) begin
         busy_in   = 1'b1;
         step_in   = STEP_W'(DATA_W - 1);
         rem_in    = '0;
         quo_in    = mag_a;
         dsr_in    = mag_b;
         is_mod_in = div_req.is_mod;
         neg_q_in  = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         neg_r_in  = div_req.dividend[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dsr_ff    <= dsr_in;
      is_mod_ff <= is_mod_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.result = is_mod_ff ? (neg_r_ff ? (~rem_ff + 1'b1) : rem_ff)
                                     : (neg_q_ff ? (~quo_ff + 1'b1) : quo_ff);

   `HKC_ASSERT(a_div_no_restart, clock, reset, busy_ff |-> !div_req.start)
   `HKC_ASSERT_NEXT(a_div_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

/* hw/rtl/hkc_back.sv */
// ----------------------------------------------------------------------------
// hkc_back
// Execute key commands on the calculator state and register the display result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkc_back (
   input  logic                clock,
   input  logic                reset,
   input  hkc_pkg::q_stat_type q_stat,
   input  hkc_pkg::cmd_type    q_head,
   output logic                q_pop,
   hkc_rsp_if.source           rsp_chan
);
   import hkc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [DATA_W-1:0]   entry_ff, entry_in;
   logic [DATA_W-1:0]   first_ff, first_in;
   logic                new_ff, new_in;
   op_type              pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   disp_ff, disp_in;
   logic                upd_ff, upd_in;
   logic                warn_ff, warn_in;
   logic [DATA_W-1:0]   calc;
   logic [DATA_W-1:0]   back16;
   logic [DATA_W-1:0]   base;
   logic                digit_ok;
   logic                div_op;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   hkc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      case (pend_ff)
         OP_ADD:  calc = first_ff + entry_ff;
         OP_SUB:  calc = first_ff - entry_ff;
         OP_MUL:  calc = first_ff * entry_ff;
         OP_DIV:  calc = ALL_ONES;
         OP_MOD:  calc = ALL_ONES;
         OP_AND:  calc = first_ff & entry_ff;
         OP_OR:   calc = first_ff | entry_ff;
         OP_XOR:  calc = first_ff ^ entry_ff;
         OP_SHR:  calc = $unsigned($signed(first_ff) >>> entry_ff[STEP_W-1:0]);
         OP_SHL:  calc = first_ff << entry_ff[STEP_W-1:0];
         default: calc = entry_ff;
      endcase
   end

   assign div_op   = ((pend_ff == OP_DIV) || (pend_ff == OP_MOD)) && (entry_ff != '0);
   assign back16   = entry_ff[DATA_W-1] ? $unsigned($signed(entry_ff + 32'd15) >>> 4)
                                        : (entry_ff >> 4);
   assign base     = new_ff ? '0 : entry_ff;
   assign digit_ok = (base < DIGIT_LIMIT) || ((base == DIGIT_LIMIT) && (q_head.unit == '0));

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      first_in     = first_ff;
      new_in       = new_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      disp_in      = disp_ff;
      upd_in       = upd_ff;
      warn_in      = warn_ff;
      q_pop        = 1'b0;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty && (!rsp_valid_ff || rsp_chan.ready)) begin
               q_pop        = 1'b1;
               rsp_valid_in = 1'b1;
               upd_in       = 1'b1;
               warn_in      = 1'b0;
               case (q_head.kind)
                  KIND_DIGIT: begin
                     if (new_ff) begin
                        first_in = entry_ff;
                     end
                     new_in   = 1'b0;
                     entry_in = digit_ok ? {base[DATA_W-UNIT_W-1:0], q_head.unit} : base;
                     upd_in   = digit_ok;
                     warn_in  = !digit_ok;
                  end
                  KIND_BACK: begin
                     entry_in = back16;
                  end
                  KIND_CLEAR: begin
                     entry_in = '0;
                  end
                  KIND_OPER: begin
                     upd_in  = !new_ff;
                     new_in  = 1'b1;
                     pend_in = q_head.op;
                     if (!new_ff && div_op) begin
                        div_req.start    = 1'b1;
                        div_req.is_mod   = (pend_ff == OP_MOD);
                        div_req.dividend = first_ff;
                        div_req.divisor  = entry_ff;
                        rsp_valid_in     = 1'b0;
                        state_in         = ST_DIV;
                     end else if (!new_ff) begin
                        entry_in = calc;
                     end
                  end
                  default: begin
                     entry_in = entry_ff;
                  end
               endcase
               disp_in = entry_in;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               entry_in     = div_rsp.result;
               disp_in      = div_rsp.result;
               upd_in       = 1'b1;
               warn_in      = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_ff     <= '0;
         first_ff     <= '0;
         new_ff       <= 1'b1;
         pend_ff      <= OP_EQU;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         first_ff     <= first_in;
         new_ff       <= new_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      disp_ff <= disp_in;
      upd_ff  <= upd_in;
      warn_ff <= warn_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.display_value  = disp_ff;
   assign rsp_chan.display_update = upd_ff;
   assign rsp_chan.entry_warning  = warn_ff;

   `HKC_ASSERT(a_div_no_rsp, clock, reset, (state_ff == ST_DIV) |-> !rsp_valid_ff)
   `HKC_ASSERT(a_done_in_div, clock, reset, div_rsp.done |-> (state_ff == ST_DIV))

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the hex keypad calculator. Key requests are sent in random
// bursts while the display side stalls on its own pattern, with one long
// hold-off to fill the block. A behavioral calculator predicts each display
// response, and the responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hkc_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] value;
      logic              update;
      logic              warning;
   } display_type;

   localparam int KEY_TARGET     = 950;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 50;
   localparam int NUM_OPERATORS  = 11;

   localparam logic [KEY_W-1:0] OPERATOR_SET [NUM_OPERATORS] = '{
      CHR_PLUS, CHR_MINUS, CHR_STAR, CHR_SLASH, CHR_PCT, CHR_EQU,
      CHR_AMP, CHR_BAR, CHR_CARET, CHR_GT, CHR_LT
   };

   logic clock;
   logic reset;

   hkc_req_if req_bus ();
   hkc_rsp_if rsp_bus ();

   hex_keypad_calculator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [DATA_W-1:0] calc_entry;
   logic [DATA_W-1:0] calc_first;
   logic              calc_fresh;
   logic [KEY_W-1:0]  calc_pending;

   display_type display_queue [$];
   int unsigned error_count;
   int unsigned key_count;
   int unsigned burst_left;
   bit          long_hold_req;

   int unsigned hold_left;
   int unsigned mode_left;
   int unsigned stall_phase;
   int unsigned stall_mode;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [DATA_W-1:0] magnitude_of(logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? -v : v;
   endfunction

   function automatic logic [DATA_W-1:0] quotient_of(logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] q;
      q = magnitude_of(a) / magnitude_of(b);
      return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
   endfunction

   function automatic logic [DATA_W-1:0] remainder_of(logic [DATA_W-1:0] a,
                                                      logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = magnitude_of(a) % magnitude_of(b);
      return a[DATA_W-1] ? -r : r;
   endfunction

   function automatic logic [DATA_W-1:0] apply_operator(logic [DATA_W-1:0] a,
                                                        logic [KEY_W-1:0]  op,
                                                        logic [DATA_W-1:0] b);
      logic signed [DATA_W-1:0] sa;
      sa = a;
      case (op)
         CHR_PLUS:  return a + b;
         CHR_MINUS: return a - b;
         CHR_STAR:  return a * b;
         CHR_SLASH: return (b == '0) ? ALL_ONES : quotient_of(a, b);
         CHR_PCT:   return (b == '0) ? ALL_ONES : remainder_of(a, b);
         CHR_AMP:   return a & b;
         CHR_BAR:   return a | b;
         CHR_CARET: return a ^ b;
         CHR_GT:    return sa >>> b[STEP_W-1:0];
         CHR_LT:    return a << b[STEP_W-1:0];
         default:   return b;
      endcase
   endfunction

   function automatic display_type predict_display(key_kind_type kind, logic [KEY_W-1:0] key);
      display_type       d;
      logic [UNIT_W-1:0] unit;
      d.update  = 1'b0;
      d.warning = 1'b0;
      unit      = key[UNIT_W-1:0];
      case (kind)
         KIND_DIGIT: begin
            if (calc_fresh) begin
               calc_first = calc_entry;
               calc_entry = '0;
               calc_fresh = 1'b0;
            end
            if (calc_entry < DIGIT_LIMIT || (calc_entry == DIGIT_LIMIT && unit == '0)) begin
               calc_entry = {calc_entry[DATA_W-UNIT_W-1:0], unit};
               d.update   = 1'b1;
            end else begin
               d.warning = 1'b1;
            end
         end
         KIND_BACK: begin
            calc_entry = quotient_of(calc_entry, 32'd16);
            d.update   = 1'b1;
         end
         KIND_CLEAR: begin
            calc_entry = '0;
            d.update   = 1'b1;
         end
         default: begin
            if (!calc_fresh) begin
               calc_entry = apply_operator(calc_first, calc_pending, calc_entry);
               d.update   = 1'b1;
            end
            calc_fresh   = 1'b1;
            calc_pending = key;
         end
      endcase
      d.value = calc_entry;
      return d;
   endfunction

   function automatic bit is_known_operator(logic [KEY_W-1:0] k);
      foreach (OPERATOR_SET[i]) begin
         if (OPERATOR_SET[i] == k) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [KEY_W-1:0] unknown_operator();
      logic [KEY_W-1:0] k;
      do k = KEY_W'($urandom_range(0, 255));
      while (is_known_operator(k));
      return k;
   endfunction

   task automatic send_key(key_kind_type kind, logic [KEY_W-1:0] key);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.key_value <= key;
      do @(posedge clock);
      while (!req_bus.ready);
      display_queue.push_back(predict_display(kind, key));
      key_count++;
   endtask

   task automatic idle_cycles(int unsigned n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_paced(key_kind_type kind, logic [KEY_W-1:0] key);
      send_key(kind, key);
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 15));
         burst_left = $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_digit(logic [KEY_W-1:0] v);
      send_paced(KIND_DIGIT, v);
   endtask

   task automatic send_op(logic [KEY_W-1:0] op);
      send_paced(KIND_OPER, op);
   endtask

   // 1 << 0x3F wraps the count to 31 and leaves the most negative value
   task automatic test_shift_count();
      send_digit(8'h01);
      send_op(CHR_LT);
      send_digit(8'h03);
      send_digit(8'h0F);
      send_op(CHR_SLASH);
   endtask

   task automatic test_entry_limit();
      send_digit(8'hFF);
      repeat (6) send_digit(8'h0F);
      send_digit(8'h01);
      send_digit(8'hF0);
      send_digit(8'h05);
   endtask

   // -16 / 16 gives -1, then most negative / -1, then modulo and divide by zero
   task automatic test_signed_divide();
      send_paced(KIND_BACK, 8'hA5);
      send_op(CHR_PCT);
      send_digit(8'h00);
      send_op(CHR_SLASH);
      send_digit(8'h00);
      send_op(CHR_STAR);
   endtask

   task automatic test_operators();
      send_digit(8'h03);
      send_op(CHR_PLUS);
      send_digit(8'h05);
      send_op(CHR_MINUS);
      send_digit(8'h07);
      send_op(CHR_AMP);
      send_digit(8'h0E);
      send_op(CHR_BAR);
      send_digit(8'h05);
      send_op(CHR_CARET);
      send_digit(8'h0C);
      send_op(CHR_GT);
      send_digit(8'h01);
      send_op(8'h00);
      send_digit(8'h09);
      send_paced(KIND_CLEAR, 8'h5A);
      send_op(CHR_EQU);
   endtask

   // hold the display side while requests keep coming
   task automatic test_backpressure();
      long_hold_req = 1'b1;
      repeat (8) begin
         send_key(KIND_DIGIT, KEY_W'($urandom_range(0, 255)));
         send_key(KIND_DIGIT, KEY_W'($urandom_range(0, 255)));
         send_key(KIND_OPER, OPERATOR_SET[$urandom_range(0, NUM_OPERATORS - 1)]);
      end
   endtask

   task automatic test_random_keys();
      int unsigned choice;
      int unsigned digits;
      while (key_count < KEY_TARGET) begin
         choice = $urandom_range(0, 99);
         if (choice < 80) begin
            digits = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 3);
            repeat (digits) begin
               send_digit(KEY_W'($urandom_range(0, 255)));
               if ($urandom_range(0, 9) == 0) begin
                  send_paced($urandom_range(0, 1) ? KIND_BACK : KIND_CLEAR,
                             KEY_W'($urandom_range(0, 255)));
               end
            end
            if ($urandom_range(0, 19) == 0) begin
               send_op(unknown_operator());
            end else begin
               send_op(OPERATOR_SET[$urandom_range(0, NUM_OPERATORS - 1)]);
            end
         end else begin
            send_paced(key_kind_type'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 255)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left      = 0;
         mode_left      = 0;
         stall_phase    = 0;
         stall_mode     = 0;
      end else if (long_hold_req) begin
         long_hold_req  = 1'b0;
         hold_left      = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
         end else begin
            mode_left--;
         end
         stall_phase++;
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= (stall_phase % 4 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      display_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (display_queue.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual value %h",
                     $time, rsp_bus.display_value);
         end else begin
            want = display_queue.pop_front();
            if (rsp_bus.display_value !== want.value) begin
               error_count++;
               $display("%0t: display_value expected %h actual %h",
                        $time, want.value, rsp_bus.display_value);
            end
            if (rsp_bus.display_update !== want.update) begin
               error_count++;
               $display("%0t: display_update expected %b actual %b",
                        $time, want.update, rsp_bus.display_update);
            end
            if (rsp_bus.entry_warning !== want.warning) begin
               error_count++;
               $display("%0t: entry_warning expected %b actual %b",
                        $time, want.warning, rsp_bus.entry_warning);
            end
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = KIND_DIGIT;
      req_bus.key_value = '0;
      rsp_bus.ready     = 1'b0;
      error_count       = 0;
      key_count         = 0;
      burst_left        = 0;
      long_hold_req     = 1'b0;
      calc_entry        = '0;
      calc_first        = '0;
      calc_fresh        = 1'b1;
      calc_pending      = CHR_EQU;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_shift_count();
      test_entry_limit();
      test_signed_divide();
      test_operators();
      test_backpressure();
      test_random_keys();
      req_bus.valid <= 1'b0;
      while (display_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("hex_keypad_calculator test passed");
      end else begin
         $display("hex_keypad_calculator test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("hex_keypad_calculator test failed");
      $finish;
   end

endmodule
